// ----- rtl/mpc_pkg.sv -----
`timescale 1ns / 1ps

package mpc_pkg;

    // Pixel coordinate and fixed-point format
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;

    // Port and register widths
    localparam int PIX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;

    // Internal datapath widths
    localparam int PROD_W = COORD_BITS + STEP_W;     // pixel * step
    localparam int C_W    = PROD_W + 2;              // c_re / c_im
    localparam int Z_W    = C_W + 1;                 // z before the bound test
    localparam int M_W    = FRAC_BITS + 2;           // multiplier operand, |z| < 2
    localparam int P_W    = 2 * M_W;                 // full product
    localparam int SQ_W   = P_W - FRAC_BITS;         // x*x >> FRAC_BITS
    localparam int T_W    = P_W - FRAC_BITS + 1;     // x*y >> (FRAC_BITS-1)

    // slice = floor(2*max_iter / 5) by reciprocal multiply (exact below 2^18)
    localparam int             SLICE_SH   = 18;
    localparam logic [ITER_W-1:0] SLICE_MUL = 16'd52429;
    localparam int             SLICE_PW   = ITER_W + 1 + ITER_W + 1;

    // Blend divider: quotient never exceeds one channel
    localparam int QUO_W = CHAN_W;
    localparam int BIT_W = 3;
    localparam int REM_W = CHAN_W + ITER_W;

    // Reset values of the configuration registers
    localparam logic [COORD_W-1:0] X_MIN_RST    = 32'hE000_0000;
    localparam logic [COORD_W-1:0] Y_TOP_RST    = 32'd281857229;
    localparam logic [STEP_W-1:0]  STEP_RST     = 31'd786432;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd200;
    localparam logic [COLOR_W-1:0] OUTER_RST    = 24'h000000;
    localparam logic [COLOR_W-1:0] MIDDLE_RST   = 24'hFF0000;
    localparam logic [COLOR_W-1:0] INNER_RST    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] SET_RST      = 24'h000000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_MIN,
        REG_Y_TOP,
        REG_STEP,
        REG_MAX_ITER,
        REG_OUTER,
        REG_MIDDLE,
        REG_INNER,
        REG_SET
    } cfg_reg_t;

    // Color channel being blended
    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    // Controller to datapath
    typedef struct packed {
        logic             capture;
        logic             map;
        logic             cinit;
        logic             iter_mul;
        logic             iter_upd;
        logic             pick;
        logic             ch_mul;
        logic             div_step;
        logic             ch_end;
        logic             out_load;
        chan_t            ch;
        logic [BIT_W-1:0] bit_idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic limit_hit;
        logic bound_esc;
        logic sum_esc;
    } status_t;

endpackage

// ----- rtl/mpc_ctrl.sv -----
`timescale 1ns / 1ps

module mpc_ctrl
    import mpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_CINIT,
        ST_ITER_A,
        ST_ITER_B,
        ST_PICK,
        ST_CH_MUL,
        ST_CH_DIV,
        ST_CH_END,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    chan_t            ch_reg, ch_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             done_reg, done_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        bit_next     = bit_reg;
        done_next    = 1'b0;
        cmd          = '0;
        cmd.ch       = ch_reg;
        cmd.bit_idx  = bit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                cmd.cinit  = 1'b1;
                state_next = ST_ITER_A;
            end
            ST_ITER_A:
            begin
                cmd.iter_mul = 1'b1;
                if (status.limit_hit || status.bound_esc)
                    state_next = ST_PICK;
                else
                    state_next = ST_ITER_B;
            end
            ST_ITER_B:
            begin
                if (status.sum_esc)
                    state_next = ST_PICK;
                else
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = ST_ITER_A;
                end
            end
            ST_PICK:
            begin
                cmd.pick = 1'b1;
                if (status.limit_hit)
                    state_next = ST_FINISH;
                else
                begin
                    ch_next    = CH_RED;
                    state_next = ST_CH_MUL;
                end
            end
            ST_CH_MUL:
            begin
                cmd.ch_mul = 1'b1;
                bit_next   = '1;
                state_next = ST_CH_DIV;
            end
            ST_CH_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_CH_END;
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_CH_END:
            begin
                cmd.ch_end = 1'b1;
                if (ch_reg == CH_BLUE)
                    state_next = ST_FINISH;
                else
                begin
                    ch_next    = chan_t'(ch_reg + 2'd1);
                    state_next = ST_CH_MUL;
                end
            end
            ST_FINISH:
            begin
                cmd.out_load = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_RED;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ----- rtl/mpc_datapath.sv -----
`timescale 1ns / 1ps

module mpc_datapath
    import mpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [CHAN_W-1:0]     red,
    output logic [CHAN_W-1:0]     green,
    output logic [CHAN_W-1:0]     blue,
    output logic [ITER_W-1:0]     escape_count,
    output logic                  inside_res
);

    localparam logic signed [Z_W-1:0] Z_TWO     = Z_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic signed [Z_W-1:0] Z_NEG_TWO = -Z_TWO;
    localparam logic [SQ_W:0]         SQ_FOUR   = (SQ_W + 1)'(64'd1 << (FRAC_BITS + 2));

    // Configuration registers
    logic [COORD_W-1:0] x_min_reg, y_top_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ITER_W-1:0]  max_iter_reg;
    logic [COLOR_W-1:0] outer_reg, middle_reg, inner_reg, set_reg;

    // Work registers
    logic [COORD_BITS-1:0]   px_reg, py_reg;
    logic [PROD_W-1:0]       prod_re_reg, prod_im_reg;
    logic [ITER_W-1:0]       slice_reg;
    logic signed [C_W-1:0]   c_re_reg, c_im_reg;
    logic signed [Z_W-1:0]   x_reg, y_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [SQ_W-1:0]         sx_reg, sy_reg;
    logic [T_W-1:0]          t_reg;
    logic                    inside_reg;
    logic [COLOR_W-1:0]      base_reg, other_reg, color_reg;
    logic [ITER_W-1:0]       num_reg, den_reg;
    logic                    neg_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        quo_reg;

    // Combinational terms
    logic [SLICE_PW-1:0]     slice_prod;
    logic [PROD_W-1:0]       prod_re, prod_im;
    logic signed [M_W-1:0]   xs, ys;
    logic signed [P_W-1:0]   prod_xx, prod_yy, prod_xy;
    logic [SQ_W:0]           sq_sum;
    logic signed [Z_W-1:0]   x_next, y_next;
    logic [CHAN_W-1:0]       b_byte, o_byte;
    logic signed [CHAN_W:0]  diff;
    logic [CHAN_W-1:0]       diff_mag;
    logic [REM_W-1:0]        trial;
    logic [CHAN_W-1:0]       chan_res;
    logic                    below_slice;

    function automatic logic [CHAN_W-1:0] chan_byte(logic [COLOR_W-1:0] c, chan_t ch);
        logic [CHAN_W-1:0] r;
        case (ch)
            CH_RED:   r = c[23:16];
            CH_GREEN: r = c[15:8];
            CH_BLUE:  r = c[7:0];
            default:  r = '0;
        endcase
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg    <= X_MIN_RST;
            y_top_reg    <= Y_TOP_RST;
            step_reg     <= STEP_RST;
            max_iter_reg <= MAX_ITER_RST;
            outer_reg    <= OUTER_RST;
            middle_reg   <= MIDDLE_RST;
            inner_reg    <= INNER_RST;
            set_reg      <= SET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_MIN:    x_min_reg    <= cfg_data[COORD_W-1:0];
                REG_Y_TOP:    y_top_reg    <= cfg_data[COORD_W-1:0];
                REG_STEP:     step_reg     <= cfg_data[STEP_W-1:0];
                REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                REG_OUTER:    outer_reg    <= cfg_data[COLOR_W-1:0];
                REG_MIDDLE:   middle_reg   <= cfg_data[COLOR_W-1:0];
                REG_INNER:    inner_reg    <= cfg_data[COLOR_W-1:0];
                REG_SET:      set_reg      <= cfg_data[COLOR_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pixel mapping and slice multipliers
    assign prod_re    = PROD_W'(px_reg) * PROD_W'(step_reg);
    assign prod_im    = PROD_W'(py_reg) * PROD_W'(step_reg);
    assign slice_prod = SLICE_PW'({max_iter_reg, 1'b0}) * SLICE_PW'(SLICE_MUL);

    // Escape iteration: three products of the truncated z
    assign xs      = x_reg[M_W-1:0];
    assign ys      = y_reg[M_W-1:0];
    assign prod_xx = xs * xs;
    assign prod_yy = ys * ys;
    assign prod_xy = xs * ys;

    assign sq_sum = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign x_next = $signed({{(Z_W - SQ_W){1'b0}}, sx_reg})
                  - $signed({{(Z_W - SQ_W){1'b0}}, sy_reg})
                  + {c_re_reg[C_W-1], c_re_reg};
    assign y_next = $signed({{(Z_W - T_W){t_reg[T_W-1]}}, t_reg})
                  + {c_im_reg[C_W-1], c_im_reg};

    assign status.limit_hit = (iter_reg == max_iter_reg);
    assign status.bound_esc = (x_reg >= Z_TWO) || (x_reg <= Z_NEG_TWO)
                           || (y_reg >= Z_TWO) || (y_reg <= Z_NEG_TWO);
    assign status.sum_esc   = (sq_sum >= SQ_FOUR);

    // Blend: channel difference, divider trial and final channel value
    assign below_slice = (iter_reg < slice_reg);
    assign b_byte      = chan_byte(base_reg, cmd.ch);
    assign o_byte      = chan_byte(other_reg, cmd.ch);
    assign diff        = $signed({1'b0, o_byte}) - $signed({1'b0, b_byte});
    assign diff_mag    = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    assign trial       = REM_W'(den_reg) << cmd.bit_idx;
    assign chan_res    = neg_reg ? (b_byte - quo_reg) : (b_byte + quo_reg);

    // Datapath registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg <= pixel_x[COORD_BITS-1:0];
            py_reg <= pixel_y[COORD_BITS-1:0];
        end

        if (cmd.map)
        begin
            prod_re_reg <= prod_re;
            prod_im_reg <= prod_im;
            slice_reg   <= slice_prod[SLICE_SH+ITER_W-1:SLICE_SH];
        end

        if (cmd.cinit)
        begin
            c_re_reg <= $signed({{(C_W - COORD_W){x_min_reg[COORD_W-1]}}, x_min_reg})
                      + $signed({{(C_W - PROD_W){1'b0}}, prod_re_reg});
            c_im_reg <= $signed({{(C_W - COORD_W){y_top_reg[COORD_W-1]}}, y_top_reg})
                      - $signed({{(C_W - PROD_W){1'b0}}, prod_im_reg});
            x_reg    <= '0;
            y_reg    <= '0;
            iter_reg <= '0;
        end

        // Floor shifts are plain part-selects of the signed products
        if (cmd.iter_mul)
        begin
            sx_reg <= prod_xx[P_W-1:FRAC_BITS];
            sy_reg <= prod_yy[P_W-1:FRAC_BITS];
            t_reg  <= prod_xy[P_W-1:FRAC_BITS-1];
        end

        if (cmd.iter_upd)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            iter_reg <= iter_reg + 1'b1;
        end

        // Record the inside flag, load the set color for a pixel in the set and pick the gradient segment
        if (cmd.pick)
        begin
            inside_reg <= status.limit_hit;
            if (status.limit_hit)
                color_reg <= set_reg;
            if (below_slice)
            begin
                base_reg  <= outer_reg;
                other_reg <= middle_reg;
                num_reg   <= iter_reg;
                den_reg   <= slice_reg;
            end
            else
            begin
                base_reg  <= middle_reg;
                other_reg <= inner_reg;
                num_reg   <= iter_reg - slice_reg;
                den_reg   <= max_iter_reg - slice_reg;
            end
        end

        if (cmd.ch_mul)
        begin
            neg_reg <= diff[CHAN_W];
            rem_reg <= REM_W'(diff_mag) * REM_W'(num_reg);
            quo_reg <= '0;
        end

        // Restoring division, one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg              <= rem_reg - trial;
                quo_reg[cmd.bit_idx] <= 1'b1;
            end
        end

        if (cmd.ch_end)
        begin
            case (cmd.ch)
                CH_RED:   color_reg[23:16] <= chan_res;
                CH_GREEN: color_reg[15:8]  <= chan_res;
                CH_BLUE:  color_reg[7:0]   <= chan_res;
                default:  ;
            endcase
        end

        if (cmd.out_load)
        begin
            red          <= color_reg[23:16];
            green        <= color_reg[15:8];
            blue         <= color_reg[7:0];
            escape_count <= iter_reg;
            inside_res   <= inside_reg;
        end
    end

endmodule

// ----- rtl/mandelbrot_pixel_colorizer_core.sv -----
`timescale 1ns / 1ps

// Mandelbrot escape-time pixel colorizer.
// Input: pulse start with pixel_x / pixel_y while busy is low; the pixel is
// taken at that edge and busy rises the next cycle. Configuration writes
// (cfg_we, cfg_index, cfg_data) land at once; write them only while idle.
// Output: done is high for exactly one cycle with red, green, blue,
// escape_count and inside_res valid; the values then hold until the next
// result. The receiver cannot stall; done is never held back.
// Timing: one pixel at a time. The escape loop runs each iteration through
// the states ITER_A and ITER_B on one set of three 30x30 multipliers; a
// pixel escapes on the bound test in ITER_A or on the |z|^2 test in
// ITER_B. The color blend runs a serial 8-step divider per channel. A
// pixel in the set skips the blend.
// start may be raised again in the same cycle as done.
// Reset: asynchronous, active low; the block returns to idle and the
// configuration registers take their default view of the plane.
module mandelbrot_pixel_colorizer_core
    import mpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    output logic                  done,
    output logic [CHAN_W-1:0]     red,
    output logic [CHAN_W-1:0]     green,
    output logic [CHAN_W-1:0]     blue,
    output logic [ITER_W-1:0]     escape_count,
    output logic                  inside_res
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    mpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Arithmetic and configuration
    mpc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cmd          (cmd),
        .status       (status),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .escape_count (escape_count),
        .inside_res   (inside_res)
    );

endmodule

// ----- rtl/mpc_checker.sv -----
`timescale 1ns / 1ps

module mpc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A taken pixel keeps the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a transfer in");

    // The result strobe marks the end of work
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside end of work");

    // The result strobe is never high on consecutive cycles
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind mandelbrot_pixel_colorizer_core mpc_checker u_mpc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
